[hdl/vertex_rotate_project_macros.svh]
// Assertion macros for the vertex transform top level.
`ifndef VERTEX_ROTATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VRP_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VRP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/vrp_pkg.sv]
// Types, constants and trig table for the vertex rotate and project pipeline.
package vrp_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int ANGLE_W      = 9;
   localparam int SCREEN_REG_W = 14;
   localparam int OUT_W        = 16;
   localparam int TRIG_W       = 11;
   localparam int CSR_IDX_W    = 2;

   localparam int TRIG_SCALE     = 1000;
   localparam int BHASKARA_K     = 40500;
   localparam int HALF_TURN      = 180;
   localparam int FULL_TURN      = 360;
   localparam int QUARTER_TURN   = 90;
   localparam int CAMERA_OFFSET  = 260;
   localparam int PROJ_GAIN      = 240;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;

   // rotated coordinates grow to at most five times the input range
   localparam int ROT_W     = COORD_WIDTH + 3;
   localparam int PROD_W    = ROT_W + TRIG_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int MAG_W     = ROT_W + 9;
   // divide by 1000: multiply by ceil(2^K/1000), exact for magnitudes below 2^MAG_W
   localparam int RCP_SHIFT = MAG_W + 10;
   localparam int RCP_W     = MAG_W + 1;
   localparam int RCP_PRD_W = MAG_W + RCP_W;
   localparam longint unsigned RCP_FULL =
      ((64'd1 << RCP_SHIFT) + 64'(TRIG_SCALE - 1)) / 64'(TRIG_SCALE);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

   localparam int DEP_W = ROT_W;
   localparam int NUM_W = ROT_W + 7;
   localparam int PX_W  = NUM_W + 2;
   localparam int HS_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic signed [COORD_WIDTH-1:0] vertex_z;
      logic [ANGLE_W-1:0]            angle_x;
      logic [ANGLE_W-1:0]            angle_y;
      logic [ANGLE_W-1:0]            angle_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] screen_x;
      logic signed [OUT_W-1:0] screen_y;
   } rsp_type;

   typedef struct packed {
      logic signed [ROT_W-1:0]  x;
      logic signed [ROT_W-1:0]  y;
      logic signed [ROT_W-1:0]  z;
      logic signed [TRIG_W-1:0] sin_x;
      logic signed [TRIG_W-1:0] cos_x;
      logic signed [TRIG_W-1:0] sin_y;
      logic signed [TRIG_W-1:0] cos_y;
      logic signed [TRIG_W-1:0] sin_z;
      logic signed [TRIG_W-1:0] cos_z;
   } pipe_type;

   typedef struct packed {
      logic [DEP_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_type;

   typedef logic [TRIG_W-2:0] hs_table_type [0:HALF_TURN];

   // quotient by repeated subtraction; never above the trig scale here
   function automatic int quot_small(input int n, input int d);
      int q;
      int r;
      q = 0;
      r = n;
      for (int k = 0; k <= TRIG_SCALE; k++) begin
         if (r >= d) begin
            r = r - d;
            q = q + 1;
         end
      end
      return q;
   endfunction

   // Bhaskara I half-wave, built at elaboration
   function automatic hs_table_type build_half_sine();
      hs_table_type tbl;
      int t;
      for (int i = 0; i <= HALF_TURN; i++) begin
         t = i * (HALF_TURN - i);
         tbl[i] = (TRIG_W-1)'(quot_small(4 * t * TRIG_SCALE, BHASKARA_K - t));
      end
      return tbl;
   endfunction

   localparam hs_table_type HALF_SINE = build_half_sine();

   // one conditional subtract: inputs stay below twice a full turn
   function automatic logic [ANGLE_W-1:0] wrap_turn(input logic [ANGLE_W-1:0] deg);
      logic [ANGLE_W-1:0] r;
      r = deg;
      if (deg >= ANGLE_W'(FULL_TURN)) begin
         r = deg - ANGLE_W'(FULL_TURN);
      end
      return r;
   endfunction

   // deg already within one turn
   function automatic logic signed [TRIG_W-1:0] sine_of(input logic [ANGLE_W-1:0] deg);
      logic [ANGLE_W-1:0] back;
      logic signed [TRIG_W-1:0] s;
      back = deg - ANGLE_W'(HALF_TURN);
      if (deg <= ANGLE_W'(HALF_TURN)) begin
         s = $signed({1'b0, HALF_SINE[deg[HS_IDX_W-1:0]]});
      end else begin
         s = -$signed({1'b0, HALF_SINE[back[HS_IDX_W-1:0]]});
      end
      return s;
   endfunction

endpackage

[hdl/vrp_rot.sv]
// One plane rotation: (a*c - b*s)/1000 and (a*s + b*c)/1000 over four stages.
module vrp_rot (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic signed [vrp_pkg::ROT_W-1:0] in_a,
   input  logic signed [vrp_pkg::ROT_W-1:0] in_b,
   input  logic signed [vrp_pkg::TRIG_W-1:0] in_cos,
   input  logic signed [vrp_pkg::TRIG_W-1:0] in_sin,
   input  vrp_pkg::pipe_type                in_side,
   output logic                             out_valid,
   output logic signed [vrp_pkg::ROT_W-1:0] out_diff,
   output logic signed [vrp_pkg::ROT_W-1:0] out_sum,
   output vrp_pkg::pipe_type                out_side
);

   logic [3:0] valid_ff;
   vrp_pkg::pipe_type side_ff [0:3];

   logic signed [vrp_pkg::PROD_W-1:0] p_ac_ff, p_bs_ff, p_as_ff, p_bc_ff;
   logic [vrp_pkg::MAG_W-1:0] mag_d_ff, mag_s_ff;
   logic neg_d2_ff, neg_s2_ff, neg_d3_ff, neg_s3_ff;
   logic [vrp_pkg::RCP_PRD_W-1:0] prd_d_ff, prd_s_ff;
   logic signed [vrp_pkg::ROT_W-1:0] diff_ff, sum_ff;

   logic signed [vrp_pkg::SUM_W-1:0] diff_in, sum_in;
   logic [vrp_pkg::SUM_W-1:0] mag_d_in, mag_s_in;
   logic [vrp_pkg::ROT_W-1:0] q_d, q_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_comb begin
      diff_in  = vrp_pkg::SUM_W'(p_ac_ff) - vrp_pkg::SUM_W'(p_bs_ff);
      sum_in   = vrp_pkg::SUM_W'(p_as_ff) + vrp_pkg::SUM_W'(p_bc_ff);
      mag_d_in = diff_in[vrp_pkg::SUM_W-1] ? vrp_pkg::SUM_W'(-diff_in)
                                           : vrp_pkg::SUM_W'(diff_in);
      mag_s_in = sum_in[vrp_pkg::SUM_W-1] ? vrp_pkg::SUM_W'(-sum_in)
                                          : vrp_pkg::SUM_W'(sum_in);
      q_d = prd_d_ff[vrp_pkg::RCP_PRD_W-1:vrp_pkg::RCP_SHIFT];
      q_s = prd_s_ff[vrp_pkg::RCP_PRD_W-1:vrp_pkg::RCP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // products
         p_ac_ff    <= in_a * in_cos;
         p_bs_ff    <= in_b * in_sin;
         p_as_ff    <= in_a * in_sin;
         p_bc_ff    <= in_b * in_cos;
         side_ff[0] <= in_side;
         // sums as sign and magnitude
         mag_d_ff   <= mag_d_in[vrp_pkg::MAG_W-1:0];
         mag_s_ff   <= mag_s_in[vrp_pkg::MAG_W-1:0];
         neg_d2_ff  <= diff_in[vrp_pkg::SUM_W-1];
         neg_s2_ff  <= sum_in[vrp_pkg::SUM_W-1];
         side_ff[1] <= side_ff[0];
         // reciprocal multiply
         prd_d_ff   <= vrp_pkg::RCP_PRD_W'(mag_d_ff) * vrp_pkg::RCP_PRD_W'(vrp_pkg::RCP);
         prd_s_ff   <= vrp_pkg::RCP_PRD_W'(mag_s_ff) * vrp_pkg::RCP_PRD_W'(vrp_pkg::RCP);
         neg_d3_ff  <= neg_d2_ff;
         neg_s3_ff  <= neg_s2_ff;
         side_ff[2] <= side_ff[1];
         // restore sign, truncation toward zero
         diff_ff    <= neg_d3_ff ? -$signed(q_d) : $signed(q_d);
         sum_ff     <= neg_s3_ff ? -$signed(q_s) : $signed(q_s);
         side_ff[3] <= side_ff[2];
      end
   end

   assign out_valid = valid_ff[3];
   assign out_diff  = diff_ff;
   assign out_sum   = sum_ff;
   assign out_side  = side_ff[3];

endmodule

[hdl/vrp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two dividends per divisor.
module vrp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [vrp_pkg::NUM_W-1:0]   in_mag_x,
   input  logic                        in_neg_x,
   input  logic [vrp_pkg::NUM_W-1:0]   in_mag_y,
   input  logic                        in_neg_y,
   input  logic [vrp_pkg::DEP_W-1:0]   in_depth,
   output logic                        out_valid,
   output logic [vrp_pkg::NUM_W-1:0]   out_quot_x,
   output logic                        out_neg_x,
   output logic [vrp_pkg::NUM_W-1:0]   out_quot_y,
   output logic                        out_neg_y
);

   localparam int N = vrp_pkg::NUM_W;

   logic [N-1:0] valid_ff;
   logic [N-1:0] neg_x_ff, neg_y_ff;
   vrp_pkg::div_type dx_ff [0:N-1];
   vrp_pkg::div_type dy_ff [0:N-1];
   logic [vrp_pkg::DEP_W-1:0] dep_ff [0:N-2];

   vrp_pkg::div_type dx_in [0:N-1];
   vrp_pkg::div_type dy_in [0:N-1];

   function automatic vrp_pkg::div_type div_step(input vrp_pkg::div_type cur,
                                                 input logic [vrp_pkg::DEP_W-1:0] d);
      logic [vrp_pkg::DEP_W:0] trial;
      vrp_pkg::div_type nxt;
      trial   = {cur.rem, cur.num[N-1]};
      nxt.num = {cur.num[N-2:0], 1'b0};
      nxt.rem = trial[vrp_pkg::DEP_W-1:0];
      if (trial >= {1'b0, d}) begin
         nxt.rem    = vrp_pkg::DEP_W'(trial - {1'b0, d});
         nxt.num[0] = 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      dx_in[0] = div_step('{rem: '0, num: in_mag_x}, in_depth);
      dy_in[0] = div_step('{rem: '0, num: in_mag_y}, in_depth);
      for (int i = 1; i < N; i++) begin
         dx_in[i] = div_step(dx_ff[i-1], dep_ff[i-1]);
         dy_in[i] = div_step(dy_ff[i-1], dep_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dep_ff[0] <= in_depth;
         neg_x_ff  <= {neg_x_ff[N-2:0], in_neg_x};
         neg_y_ff  <= {neg_y_ff[N-2:0], in_neg_y};
         for (int i = 1; i < N-1; i++) begin
            dep_ff[i] <= dep_ff[i-1];
         end
         for (int i = 0; i < N; i++) begin
            dx_ff[i] <= dx_in[i];
            dy_ff[i] <= dy_in[i];
         end
      end
   end

   assign out_valid  = valid_ff[N-1];
   assign out_quot_x = dx_ff[N-1].num;
   assign out_quot_y = dy_ff[N-1].num;
   assign out_neg_x  = neg_x_ff[N-1];
   assign out_neg_y  = neg_y_ff[N-1];

endmodule

[hdl/vertex_rotate_project.sv]
// Top level: rotates a vertex by three angles and projects it to screen coordinates.
//
// Usage
//   req channel (req_valid/req_ready/req_data): one vertex plus three angles in
//   whole degrees per item. rsp channel (rsp_valid/rsp_ready/rsp_data): one
//   screen_x/screen_y item per request, in request order.
//   csr channel: csr_index 0 writes screen width, 1 screen height; other
//   indexes are ignored. csr_ready is always high; write only while idle.
// Timing
//   From the accepting edge to rsp_valid an item passes one trig lookup stage,
//   three four-stage rotation units, a projection set-up stage, a NUM_W-stage
//   restoring divider and a saturation stage, then a two-entry output buffer.
//   One item per cycle is taken while the output buffer is not full.
// Reset
//   Synchronous, active high: the pipeline and output buffer empty, screen
//   size returns to 640 x 480.
// Back-pressure
//   With rsp_ready low the buffer absorbs one item and the pipeline keeps
//   moving; once two items wait, the whole pipeline holds and req_ready drops.
module vertex_rotate_project (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  vrp_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output vrp_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vrp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vrp_pkg::SCREEN_REG_W-1:0]   csr_wdata
);

`include "vertex_rotate_project_macros.svh"

   localparam logic [1:0] BUF_EMPTY = 2'd0;
   localparam logic [1:0] BUF_ONE   = 2'd1;
   localparam logic [1:0] BUF_FULL  = 2'd2;

   // ---------------------------------------------------------------- config
   logic [vrp_pkg::SCREEN_REG_W-1:0] width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= vrp_pkg::SCREEN_REG_W'(vrp_pkg::WIDTH_RESET);
         height_ff <= vrp_pkg::SCREEN_REG_W'(vrp_pkg::HEIGHT_RESET);
      end else if (csr_valid) begin
         if (csr_index == vrp_pkg::REG_SCREEN_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_index == vrp_pkg::REG_SCREEN_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   // Single pipeline enable, taken straight from the output buffer fill.
   logic [1:0] cnt_ff;
   logic       adv;

   assign adv       = (cnt_ff != BUF_FULL);
   assign req_ready = adv;

   // ------------------------------------------------------ trig lookup stage
   logic              t1_valid_ff;
   vrp_pkg::pipe_type t1_ff, t1_in;

   function automatic vrp_pkg::pipe_type load_item(input vrp_pkg::req_type r);
      vrp_pkg::pipe_type p;
      logic [vrp_pkg::ANGLE_W-1:0] rx, ry, rz;
      rx = vrp_pkg::wrap_turn(r.angle_x);
      ry = vrp_pkg::wrap_turn(r.angle_y);
      rz = vrp_pkg::wrap_turn(r.angle_z);
      p.x = vrp_pkg::ROT_W'(r.vertex_x);
      p.y = vrp_pkg::ROT_W'(r.vertex_y);
      p.z = vrp_pkg::ROT_W'(r.vertex_z);
      p.sin_x = vrp_pkg::sine_of(rx);
      p.sin_y = vrp_pkg::sine_of(ry);
      p.sin_z = vrp_pkg::sine_of(rz);
      // cosine is the sine a quarter turn on
      p.cos_x = vrp_pkg::sine_of(vrp_pkg::wrap_turn(rx + vrp_pkg::ANGLE_W'(vrp_pkg::QUARTER_TURN)));
      p.cos_y = vrp_pkg::sine_of(vrp_pkg::wrap_turn(ry + vrp_pkg::ANGLE_W'(vrp_pkg::QUARTER_TURN)));
      p.cos_z = vrp_pkg::sine_of(vrp_pkg::wrap_turn(rz + vrp_pkg::ANGLE_W'(vrp_pkg::QUARTER_TURN)));
      return p;
   endfunction

   assign t1_in = load_item(req_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else if (adv) begin
         t1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= t1_in;
      end
   end

   // ------------------------------------------------------------ rotations
   // about X: y1 = y*cx - z*sx, z1 = y*sx + z*cx
   logic                            rx_valid;
   logic signed [vrp_pkg::ROT_W-1:0] rx_diff, rx_sum;
   vrp_pkg::pipe_type               rx_side, rx_pipe;

   vrp_rot u_rot_x (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv),
      .in_valid (t1_valid_ff),
      .in_a     (t1_ff.y),
      .in_b     (t1_ff.z),
      .in_cos   (t1_ff.cos_x),
      .in_sin   (t1_ff.sin_x),
      .in_side  (t1_ff),
      .out_valid(rx_valid),
      .out_diff (rx_diff),
      .out_sum  (rx_sum),
      .out_side (rx_side)
   );

   always_comb begin
      rx_pipe   = rx_side;
      rx_pipe.y = rx_diff;
      rx_pipe.z = rx_sum;
   end

   // about Y: z2 = z1*cy - x*sy, x2 = z1*sy + x*cy
   logic                            ry_valid;
   logic signed [vrp_pkg::ROT_W-1:0] ry_diff, ry_sum;
   vrp_pkg::pipe_type               ry_side, ry_pipe;

   vrp_rot u_rot_y (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv),
      .in_valid (rx_valid),
      .in_a     (rx_pipe.z),
      .in_b     (rx_pipe.x),
      .in_cos   (rx_pipe.cos_y),
      .in_sin   (rx_pipe.sin_y),
      .in_side  (rx_pipe),
      .out_valid(ry_valid),
      .out_diff (ry_diff),
      .out_sum  (ry_sum),
      .out_side (ry_side)
   );

   always_comb begin
      ry_pipe   = ry_side;
      ry_pipe.z = ry_diff;
      ry_pipe.x = ry_sum;
   end

   // about Z: x3 = x2*cz - y1*sz, y3 = x2*sz + y1*cz
   logic                            rz_valid;
   logic signed [vrp_pkg::ROT_W-1:0] rz_diff, rz_sum;
   vrp_pkg::pipe_type               rz_side;

   vrp_rot u_rot_z (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv),
      .in_valid (ry_valid),
      .in_a     (ry_pipe.x),
      .in_b     (ry_pipe.y),
      .in_cos   (ry_pipe.cos_z),
      .in_sin   (ry_pipe.sin_z),
      .in_side  (ry_pipe),
      .out_valid(rz_valid),
      .out_diff (rz_diff),
      .out_sum  (rz_sum),
      .out_side (rz_side)
   );

   // ------------------------------------------------------ projection set-up
   // depth = z3 + 260 clamped to 1; dividends 240*x3, 240*y3 as sign/magnitude
   logic                            prep_valid_ff;
   logic [vrp_pkg::DEP_W-1:0]       prep_depth_ff;
   logic [vrp_pkg::NUM_W-1:0]       prep_mag_x_ff, prep_mag_y_ff;
   logic                            prep_neg_x_ff, prep_neg_y_ff;

   logic signed [vrp_pkg::ROT_W:0]   depth_in;
   logic signed [vrp_pkg::NUM_W:0]   num_x_in, num_y_in;
   logic [vrp_pkg::NUM_W:0]          mag_x_in, mag_y_in;
   logic [vrp_pkg::DEP_W-1:0]        dep_in;

   always_comb begin
      depth_in = (vrp_pkg::ROT_W+1)'(rz_side.z) + (vrp_pkg::ROT_W+1)'(vrp_pkg::CAMERA_OFFSET);
      dep_in   = depth_in[vrp_pkg::DEP_W-1:0];
      if (depth_in < (vrp_pkg::ROT_W+1)'(1)) begin
         dep_in = vrp_pkg::DEP_W'(1);
      end
      num_x_in = (vrp_pkg::NUM_W+1)'(rz_diff) * (vrp_pkg::NUM_W+1)'(vrp_pkg::PROJ_GAIN);
      num_y_in = (vrp_pkg::NUM_W+1)'(rz_sum) * (vrp_pkg::NUM_W+1)'(vrp_pkg::PROJ_GAIN);
      mag_x_in = num_x_in[vrp_pkg::NUM_W] ? (vrp_pkg::NUM_W+1)'(-num_x_in)
                                          : (vrp_pkg::NUM_W+1)'(num_x_in);
      mag_y_in = num_y_in[vrp_pkg::NUM_W] ? (vrp_pkg::NUM_W+1)'(-num_y_in)
                                          : (vrp_pkg::NUM_W+1)'(num_y_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= rz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_depth_ff <= dep_in;
         prep_mag_x_ff <= mag_x_in[vrp_pkg::NUM_W-1:0];
         prep_mag_y_ff <= mag_y_in[vrp_pkg::NUM_W-1:0];
         prep_neg_x_ff <= num_x_in[vrp_pkg::NUM_W];
         prep_neg_y_ff <= num_y_in[vrp_pkg::NUM_W];
      end
   end

   // ---------------------------------------------------------------- divide
   logic                      dv_valid;
   logic [vrp_pkg::NUM_W-1:0] dv_quot_x, dv_quot_y;
   logic                      dv_neg_x, dv_neg_y;

   vrp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (prep_valid_ff),
      .in_mag_x  (prep_mag_x_ff),
      .in_neg_x  (prep_neg_x_ff),
      .in_mag_y  (prep_mag_y_ff),
      .in_neg_y  (prep_neg_y_ff),
      .in_depth  (prep_depth_ff),
      .out_valid (dv_valid),
      .out_quot_x(dv_quot_x),
      .out_neg_x (dv_neg_x),
      .out_quot_y(dv_quot_y),
      .out_neg_y (dv_neg_y)
   );

   // ------------------------------------------------------ centre + saturate
   localparam logic signed [vrp_pkg::PX_W-1:0] SAT_HI = vrp_pkg::PX_W'(32767);
   localparam logic signed [vrp_pkg::PX_W-1:0] SAT_LO = vrp_pkg::PX_W'(-32768);

   function automatic logic signed [vrp_pkg::OUT_W-1:0] sat16(
      input logic signed [vrp_pkg::PX_W-1:0] v);
      logic signed [vrp_pkg::OUT_W-1:0] r;
      r = v[vrp_pkg::OUT_W-1:0];
      if (v > SAT_HI) begin
         r = vrp_pkg::OUT_W'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = vrp_pkg::OUT_W'(SAT_LO);
      end
      return r;
   endfunction

   logic                            fin_valid_ff;
   vrp_pkg::rsp_type                fin_ff;
   logic signed [vrp_pkg::PX_W-1:0] ctr_x, ctr_y, qx, qy, px_in, py_in;

   always_comb begin
      ctr_x = vrp_pkg::PX_W'({1'b0, width_ff[vrp_pkg::SCREEN_REG_W-1:1]});
      ctr_y = vrp_pkg::PX_W'({1'b0, height_ff[vrp_pkg::SCREEN_REG_W-1:1]});
      qx    = vrp_pkg::PX_W'({1'b0, dv_quot_x});
      qy    = vrp_pkg::PX_W'({1'b0, dv_quot_y});
      // x adds the signed quotient, y subtracts it
      px_in = dv_neg_x ? ctr_x - qx : ctr_x + qx;
      py_in = dv_neg_y ? ctr_y + qy : ctr_y - qy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff.screen_x <= sat16(px_in);
         fin_ff.screen_y <= sat16(py_in);
      end
   end

   // ---------------------------------------------------------- output buffer
   // Two entries: head drives rsp_data, tail catches one item during a stall.
   vrp_pkg::rsp_type head_ff, tail_ff;
   logic             push, pop;

   assign push      = adv && fin_valid_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != BUF_EMPTY);
   assign rsp_data  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= BUF_EMPTY;
      end else begin
         unique case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case ({push, pop})
         2'b10: begin
            if (cnt_ff == BUF_EMPTY) begin
               head_ff <= fin_ff;
            end else begin
               tail_ff <= fin_ff;
            end
         end
         2'b01: begin
            head_ff <= tail_ff;
         end
         2'b11: begin
            // only reachable with one entry held
            head_ff <= fin_ff;
         end
         default: begin
            head_ff <= head_ff;
         end
      endcase
   end

   // ------------------------------------------------------------- assertions
   `VRP_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, t1_valid_ff, "accepted item lost at entry")
   `VRP_ASSERT_NOW(a_depth_nonzero, prep_valid_ff, prep_depth_ff != '0, "zero divisor reached divider")
   `VRP_ASSERT_NEXT(a_last_pop_drains, pop && !push && (cnt_ff == BUF_ONE), !rsp_valid, "buffer not drained")

endmodule

[tb/sv/vertex_rotate_project_tb.sv]
// Testbench for vertex_rotate_project: random and directed vertices checked against a predictor.
`timescale 1ns / 1ps

class projection_board;
   vrp_pkg::rsp_type pending_q[$];
   int unsigned width_px;
   int unsigned height_px;
   int mismatches;

   function new();
      width_px   = vrp_pkg::WIDTH_RESET;
      height_px  = vrp_pkg::HEIGHT_RESET;
      mismatches = 0;
   endfunction

   // Bhaskara half-wave, x within [0,180]
   function longint bhaskara(longint x);
      longint t;
      t = x * (180 - x);
      return (4 * t * 1000) / (40500 - t);
   endfunction

   function longint sine_deg(int unsigned deg);
      longint x;
      x = deg % 360;
      if (x <= 180) return bhaskara(x);
      return -bhaskara(x - 180);
   endfunction

   function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function void set_screen(logic [vrp_pkg::CSR_IDX_W-1:0] idx,
                             logic [vrp_pkg::SCREEN_REG_W-1:0] val);
      if (idx == vrp_pkg::REG_SCREEN_WIDTH) width_px = 32'(val);
      else if (idx == vrp_pkg::REG_SCREEN_HEIGHT) height_px = 32'(val);
   endfunction

   // work out the projected point for an accepted vertex
   function void note_vertex(vrp_pkg::req_type r);
      longint vx, vy, vz, sx, cx, sy, cy, sz, cz;
      longint y1, z1, x2, z2, x3, y3, depth;
      vrp_pkg::rsp_type e;
      vx = longint'(r.vertex_x); vy = longint'(r.vertex_y); vz = longint'(r.vertex_z);
      sx = sine_deg(32'(r.angle_x)); cx = sine_deg(32'(r.angle_x) % 360 + 90);
      sy = sine_deg(32'(r.angle_y)); cy = sine_deg(32'(r.angle_y) % 360 + 90);
      sz = sine_deg(32'(r.angle_z)); cz = sine_deg(32'(r.angle_z) % 360 + 90);
      y1 = (vy * cx - vz * sx) / 1000;
      z1 = (vy * sx + vz * cx) / 1000;
      x2 = (vx * cy + z1 * sy) / 1000;
      z2 = (-vx * sy + z1 * cy) / 1000;
      x3 = (x2 * cz - y1 * sz) / 1000;
      y3 = (x2 * sz + y1 * cz) / 1000;
      depth = z2 + 260;
      if (depth < 1) depth = 1;
      e.screen_x = 16'(clip16(longint'(width_px / 2) + (x3 * 240) / depth));
      e.screen_y = 16'(clip16(longint'(height_px / 2) - (y3 * 240) / depth));
      pending_q.push_back(e);
   endfunction

   function void check_point(vrp_pkg::rsp_type got);
      vrp_pkg::rsp_type e;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected item: x %0d y %0d",
                                        got.screen_x, got.screen_y);
         return;
      end
      e = pending_q.pop_front();
      if (got.screen_x !== e.screen_x || got.screen_y !== e.screen_y) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected x %0d y %0d, got x %0d y %0d",
                     e.screen_x, e.screen_y, got.screen_x, got.screen_y);
      end
   endfunction
endclass

module vertex_rotate_project_tb;

   localparam int LATENCY   = 40;
   localparam int STALL_CAP = 20000;
   localparam int REQ_BITS  = $bits(vrp_pkg::req_type);

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, csr_valid, csr_ready;
   logic rsp_ready = 1'b0;
   vrp_pkg::req_type req_data;
   vrp_pkg::rsp_type rsp_data;
   logic [vrp_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [vrp_pkg::SCREEN_REG_W-1:0] csr_wdata;

   // idle and stall odds, in percent
   int send_gap, recv_gap;
   bit hold_off;
   int quiet_cycles;
   projection_board board;

   vertex_rotate_project u_top (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // results: sampled at the rising edge, ready changed at the falling one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_point(rsp_data);
   end

   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_gap);
   end

   // watchdog: cycles with nothing accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || csr_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_CAP) begin
         $display("[vertex_rotate_project] ERROR");
         $finish;
      end
   end

   // valid stays up after acceptance; drain() or an idle gap in the next call lowers it
   task automatic send_vertex(vrp_pkg::req_type r);
      while ($urandom_range(99) < send_gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note_vertex(r);
      @(negedge clock);
   endtask

   task automatic write_screen(logic [vrp_pkg::CSR_IDX_W-1:0] idx,
                               logic [vrp_pkg::SCREEN_REG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.set_screen(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // block is idle once nothing is owed and the pipe has had time to drain
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic vrp_pkg::req_type any_vertex();
      vrp_pkg::req_type r;
      r = vrp_pkg::req_type'(REQ_BITS'({$urandom, $urandom}));
      // mostly near the camera so the projection stays on screen
      if ($urandom_range(3) != 0) begin
         r.vertex_x = vrp_pkg::COORD_WIDTH'($signed($urandom_range(400)) - 200);
         r.vertex_y = vrp_pkg::COORD_WIDTH'($signed($urandom_range(400)) - 200);
         r.vertex_z = vrp_pkg::COORD_WIDTH'($signed($urandom_range(400)) - 200);
         r.angle_x  = vrp_pkg::ANGLE_W'($urandom_range(359));
         r.angle_y  = vrp_pkg::ANGLE_W'($urandom_range(359));
         r.angle_z  = vrp_pkg::ANGLE_W'($urandom_range(359));
      end
      return r;
   endfunction

   function automatic vrp_pkg::req_type mk(int x, int y, int z, int ax, int ay, int az);
      vrp_pkg::req_type r;
      r.vertex_x = vrp_pkg::COORD_WIDTH'(x);
      r.vertex_y = vrp_pkg::COORD_WIDTH'(y);
      r.vertex_z = vrp_pkg::COORD_WIDTH'(z);
      r.angle_x = vrp_pkg::ANGLE_W'(ax);
      r.angle_y = vrp_pkg::ANGLE_W'(ay);
      r.angle_z = vrp_pkg::ANGLE_W'(az);
      return r;
   endfunction

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      send_gap = 0; recv_gap = 0; hold_off = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, angle wrap beyond a turn, vertex behind camera
      send_vertex(mk(0, 0, 0, 0, 0, 0));
      send_vertex(mk(2047, 2047, 2047, 0, 0, 0));
      send_vertex(mk(-2048, -2048, -2048, 0, 0, 0));
      send_vertex(mk(100, 50, -2048, 0, 0, 0));        // depth clamps to 1
      send_vertex(mk(2047, -2048, -259, 0, 0, 0));     // saturates both coordinates
      send_vertex(mk(100, 100, 100, 90, 180, 270));
      send_vertex(mk(100, 100, 100, 359, 360, 511));   // angles past a turn
      send_vertex(mk(-100, 77, 33, 181, 45, 135));
      send_vertex(mk(2047, 2047, -2048, 511, 511, 511));
      send_vertex(mk(-2048, 0, 2047, 1, 179, 450));
      drain();

      // settings sweep: extremes, zero and out-of-range, index past the list
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_screen(vrp_pkg::REG_SCREEN_WIDTH, vrp_pkg::SCREEN_REG_W'(1));
                     write_screen(vrp_pkg::REG_SCREEN_HEIGHT, vrp_pkg::SCREEN_REG_W'(8192)); end
            1: begin write_screen(vrp_pkg::REG_SCREEN_WIDTH, vrp_pkg::SCREEN_REG_W'(8192));
                     write_screen(vrp_pkg::REG_SCREEN_HEIGHT, vrp_pkg::SCREEN_REG_W'(1)); end
            2: begin write_screen(vrp_pkg::REG_SCREEN_WIDTH, vrp_pkg::SCREEN_REG_W'(0));
                     write_screen(vrp_pkg::REG_SCREEN_HEIGHT, 14'h3FFF); end
            3: begin write_screen(vrp_pkg::REG_SCREEN_WIDTH, 14'h3FFF);
                     write_screen(vrp_pkg::REG_SCREEN_HEIGHT, vrp_pkg::SCREEN_REG_W'(0));
                     write_screen(vrp_pkg::CSR_IDX_W'(3), 14'h1234); end
            default: begin
               write_screen(vrp_pkg::REG_SCREEN_WIDTH, vrp_pkg::SCREEN_REG_W'($urandom));
               write_screen(vrp_pkg::REG_SCREEN_HEIGHT, vrp_pkg::SCREEN_REG_W'($urandom));
               write_screen(vrp_pkg::CSR_IDX_W'(2), vrp_pkg::SCREEN_REG_W'($urandom));
            end
         endcase
         case (phase % 4)
            0: begin send_gap = 0;  recv_gap = 0;  end
            1: begin send_gap = 78; recv_gap = 0;  end
            2: begin send_gap = 0;  recv_gap = 78; end
            default: begin send_gap = 15; recv_gap = 15; end
         endcase
         if (phase == 4) begin
            // long hold-off: pipeline fills and req_ready must drop
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(negedge clock);
                  hold_off = 1'b0;
               end
               repeat (120) send_vertex(any_vertex());
            join
         end else begin
            repeat (120) send_vertex(any_vertex());
         end
         send_gap = 0; recv_gap = 0;
         drain();
      end
      write_screen(vrp_pkg::REG_SCREEN_WIDTH, vrp_pkg::SCREEN_REG_W'(640));
      write_screen(vrp_pkg::REG_SCREEN_HEIGHT, vrp_pkg::SCREEN_REG_W'(480));
      repeat (40) send_vertex(any_vertex());
      drain();

      if (board.mismatches == 0 && board.pending_q.size() == 0)
         $display("[vertex_rotate_project] OK");
      else
         $display("[vertex_rotate_project] ERROR");
      $finish;
   end
endmodule
